/* rtl/sse_pkg.sv */
// Shared constants, codes and defaults for the shake/switch event correlator.
package sse_pkg;

   localparam int DATA_W = 32;

   // Default ring depths, handed to the top level as parameter defaults.
   localparam int SSE_SHAKE_DEPTH  = 16;
   localparam int SSE_SWITCH_DEPTH = 16;

   // Register reset values.
   localparam logic [DATA_W-1:0] SHAKE_HOLDOFF_RST  = 32'd1000;
   localparam logic [DATA_W-1:0] SWITCH_HOLDOFF_RST = 32'd500;
   localparam logic [DATA_W-1:0] GAP_MIN_RST        = 32'd1000;
   localparam logic [DATA_W-1:0] GAP_SUM_MIN_RST    = 32'd10000;
   localparam logic [DATA_W-1:0] MATCH_WINDOW_RST   = 32'd1000;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SHAKE_HOLDOFF  = 3'd0,
      REG_SWITCH_HOLDOFF = 3'd1,
      REG_GAP_MIN        = 3'd2,
      REG_GAP_SUM_MIN    = 3'd3,
      REG_MATCH_WINDOW   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_SHAKE   = 2'd0,
      CMD_SWITCH  = 2'd1,
      CMD_ANALYZE = 2'd2,
      CMD_CLEAR   = 2'd3
   } command_type;

endpackage

/* rtl/sse_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module sse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sse_ring.sv */
// Timestamp ring: a RAM plus per-entry valid bits so that empty slots read as zero.
module sse_ring
   import sse_pkg::*;
#(
   parameter int WIDTH = DATA_W,
   parameter int DEPTH = SSE_SHAKE_DEPTH,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [DEPTH-1:0] valid_ff;
   logic             rd_valid_ff;
   logic [WIDTH-1:0] ram_q;

   sse_ram #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // A slot that was never written since reset or the last clear reads as zero.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? ram_q : '0;

endmodule

/* rtl/shake_switch_event_correlator.sv */
// Top level of the shake/switch event correlator: command decode, rings and analysis sequencer.
//
// Usage: a transaction is offered with start and taken at a clock edge where start is high
// and busy is low. req_command selects a vibration event, a switch event, analyze or clear;
// req_timestamp carries the event time. Event and clear transactions complete in the cycle
// they are taken and never raise busy, so they may follow one another every cycle.
// Analyze raises busy and produces exactly one result, shown for a single cycle with
// rsp_valid high; the receiver cannot hold it off. busy drops in the cycle the result is
// shown, so the next transaction may be offered alongside it.
// Analyze runs, with D = SHAKE_DEPTH and S = SWITCH_DEPTH, D-1 bubble sort passes through
// the vibration RAM, then a pass that sums the gaps, then the pair search over up to S switch
// entries, which stops at the first match. The single read port of the vibration RAM, one
// entry per cycle, sets the pace of each of these steps.
// Configuration registers are written through the csr_ port at any edge where csr_we is
// high; they should only change while busy is low.
// Synchronous reset restores the register defaults, empties both rings and zeroes the
// last-event times; no result is pending after reset.
module shake_switch_event_correlator
   import sse_pkg::*;
#(
   parameter int SHAKE_DEPTH  = SSE_SHAKE_DEPTH,
   parameter int SWITCH_DEPTH = SSE_SWITCH_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   // Command transaction.
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_command,
   input  logic [DATA_W-1:0]    req_timestamp,
   // Result transaction.
   output logic                 rsp_valid,
   output logic                 rsp_match_found,
   output logic [DATA_W-1:0]    rsp_switch_time,
   output logic [DATA_W-1:0]    rsp_shake_time,
   // Configuration writes.
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam int SH_AW = (SHAKE_DEPTH > 1) ? $clog2(SHAKE_DEPTH) : 1;
   localparam int SW_AW = (SWITCH_DEPTH > 1) ? $clog2(SWITCH_DEPTH) : 1;
   // The sequencer counter runs from 0 to SHAKE_DEPTH+1 within a pass.
   localparam int CNT_W = $clog2(SHAKE_DEPTH + 2);

   localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(SHAKE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(SHAKE_DEPTH + 1);
   localparam logic [SH_AW-1:0] PASS_LAST = SH_AW'(SHAKE_DEPTH - 2);
   localparam logic [SH_AW-1:0] SH_TOP    = SH_AW'(SHAKE_DEPTH - 1);
   localparam logic [SW_AW-1:0] SW_TOP    = SW_AW'(SWITCH_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT,
      ST_GAP,
      ST_SW_RD,
      ST_SW_CHK,
      ST_SCAN
   } state_type;

   // Configuration registers.
   logic [DATA_W-1:0] shake_holdoff_ff;
   logic [DATA_W-1:0] switch_holdoff_ff;
   logic [DATA_W-1:0] gap_min_ff;
   logic [DATA_W-1:0] gap_sum_min_ff;
   logic [DATA_W-1:0] match_window_ff;

   // Event bookkeeping.
   logic [SH_AW-1:0]  shake_pos_ff;
   logic [SW_AW-1:0]  switch_pos_ff;
   logic [DATA_W-1:0] last_shake_ff;
   logic [DATA_W-1:0] last_switch_ff;

   // Sequencer state.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SH_AW-1:0]  pass_ff, pass_in;
   logic [DATA_W-1:0] carry_ff, carry_in;
   logic [DATA_W-1:0] prev_ff, prev_in;
   logic [DATA_W-1:0] sum_ff, sum_in;
   logic              sum_ok_ff, sum_ok_in;
   logic [SW_AW-1:0]  sw_idx_ff, sw_idx_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [DATA_W-1:0] rsp_sw_ff, rsp_sw_in;
   logic [DATA_W-1:0] rsp_sh_ff, rsp_sh_in;

   logic              accept;
   logic              ev_shake_we;
   logic              ev_switch_we;
   logic              ring_clear;
   logic [DATA_W-1:0] shake_diff;
   logic [DATA_W-1:0] switch_diff;

   logic              sort_we;
   logic [SH_AW-1:0]  sort_waddr;
   logic [DATA_W-1:0] sort_wdata;
   logic [CNT_W-1:0]  cnt_m2;
   logic              sh_rd_en;
   logic [SH_AW-1:0]  sh_rd_addr;
   logic [DATA_W-1:0] sh_rd_data;
   logic              sw_rd_en;
   logic [SW_AW-1:0]  sw_rd_addr;
   logic [DATA_W-1:0] sw_rd_data;
   logic              sh_wr_en;
   logic [SH_AW-1:0]  sh_wr_addr;
   logic [DATA_W-1:0] sh_wr_data;

   logic [DATA_W-1:0] gap;
   logic [DATA_W-1:0] abs_diff;
   logic              finish;
   logic              found;
   logic              report;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Event decode. Hold-off distances are taken modulo 2^32.
   assign shake_diff  = req_timestamp - last_shake_ff;
   assign switch_diff = req_timestamp - last_switch_ff;

   always_comb begin
      ev_shake_we  = 1'b0;
      ev_switch_we = 1'b0;
      ring_clear   = 1'b0;
      if (accept) begin
         case (req_command)
            CMD_SHAKE: begin
               ev_shake_we = (shake_diff >= shake_holdoff_ff);
            end
            CMD_SWITCH: begin
               ev_switch_we = (switch_diff > switch_holdoff_ff);
            end
            CMD_CLEAR: begin
               ring_clear = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shake_holdoff_ff  <= SHAKE_HOLDOFF_RST;
         switch_holdoff_ff <= SWITCH_HOLDOFF_RST;
         gap_min_ff        <= GAP_MIN_RST;
         gap_sum_min_ff    <= GAP_SUM_MIN_RST;
         match_window_ff   <= MATCH_WINDOW_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_SHAKE_HOLDOFF:  shake_holdoff_ff  <= csr_wdata;
            REG_SWITCH_HOLDOFF: switch_holdoff_ff <= csr_wdata;
            REG_GAP_MIN:        gap_min_ff        <= csr_wdata;
            REG_GAP_SUM_MIN:    gap_sum_min_ff    <= csr_wdata;
            REG_MATCH_WINDOW:   match_window_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Write slots wrap at the ring depth; the last-event times survive a clear.
   always_ff @(posedge clock) begin
      if (reset) begin
         shake_pos_ff   <= '0;
         switch_pos_ff  <= '0;
         last_shake_ff  <= '0;
         last_switch_ff <= '0;
      end else begin
         if (ring_clear) begin
            shake_pos_ff  <= '0;
            switch_pos_ff <= '0;
         end
         if (ev_shake_we) begin
            last_shake_ff <= req_timestamp;
            shake_pos_ff  <= (shake_pos_ff == SH_TOP) ? '0 : shake_pos_ff + SH_AW'(1);
         end
         if (ev_switch_we) begin
            last_switch_ff <= req_timestamp;
            switch_pos_ff  <= (switch_pos_ff == SW_TOP) ? '0 : switch_pos_ff + SW_AW'(1);
         end
      end
   end

   // The vibration RAM is written by events while idle and by the sort while busy.
   assign sh_wr_en   = ev_shake_we || sort_we;
   assign sh_wr_addr = busy ? sort_waddr : shake_pos_ff;
   assign sh_wr_data = busy ? sort_wdata : req_timestamp;

   sse_ring #(
      .WIDTH (DATA_W),
      .DEPTH (SHAKE_DEPTH)
   ) u_shake_ring (
      .clock   (clock),
      .reset   (reset),
      .clear   (ring_clear),
      .wr_en   (sh_wr_en),
      .wr_addr (sh_wr_addr),
      .wr_data (sh_wr_data),
      .rd_en   (sh_rd_en),
      .rd_addr (sh_rd_addr),
      .rd_data (sh_rd_data)
   );

   sse_ring #(
      .WIDTH (DATA_W),
      .DEPTH (SWITCH_DEPTH)
   ) u_switch_ring (
      .clock   (clock),
      .reset   (reset),
      .clear   (ring_clear),
      .wr_en   (ev_switch_we),
      .wr_addr (switch_pos_ff),
      .wr_data (req_timestamp),
      .rd_en   (sw_rd_en),
      .rd_addr (sw_rd_addr),
      .rd_data (sw_rd_data)
   );

   assign cnt_m2 = cnt_ff - CNT_W'(2);
   assign gap    = sh_rd_data - prev_ff;
   assign abs_diff = (a_ff >= sh_rd_data) ? (a_ff - sh_rd_data) : (sh_rd_data - a_ff);

   // Analysis sequencer. In a sort pass the counter issues the read of entry cnt while
   // the data of entry cnt-1 returns; the larger value rides along in carry_ff and the
   // smaller one is written back to entry cnt-2, which is a bubble pass with one
   // write per entry. The final count of a pass stores the carried maximum.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      carry_in     = carry_ff;
      prev_in      = prev_ff;
      sum_in       = sum_ff;
      sum_ok_in    = sum_ok_ff;
      sw_idx_in    = sw_idx_ff;
      a_in         = a_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_sw_in    = rsp_sw_ff;
      rsp_sh_in    = rsp_sh_ff;
      sort_we      = 1'b0;
      sort_waddr   = cnt_m2[SH_AW-1:0];
      sort_wdata   = carry_ff;
      sh_rd_en     = 1'b0;
      sh_rd_addr   = cnt_ff[SH_AW-1:0];
      sw_rd_en     = 1'b0;
      sw_rd_addr   = sw_idx_ff;
      finish       = 1'b0;
      found        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_ANALYZE)) begin
               state_in = ST_SORT;
               cnt_in   = '0;
               pass_in  = '0;
               sum_in   = '0;
            end
         end

         ST_SORT: begin
            sh_rd_en = (cnt_ff < CNT_DEPTH);
            if (cnt_ff == CNT_W'(1)) begin
               carry_in = sh_rd_data;
            end
            if (cnt_ff >= CNT_W'(2)) begin
               sort_we = 1'b1;
               if (cnt_ff != CNT_LAST) begin
                  if (carry_ff > sh_rd_data) begin
                     sort_wdata = sh_rd_data;
                  end else begin
                     sort_wdata = carry_ff;
                     carry_in   = sh_rd_data;
                  end
               end
            end
            if (cnt_ff == CNT_LAST) begin
               cnt_in = '0;
               if (pass_ff == PASS_LAST) begin
                  state_in = ST_GAP;
               end else begin
                  pass_in = pass_ff + SH_AW'(1);
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         ST_GAP: begin
            // Adjacent sorted entries, both nonzero, contribute gaps above gap_min.
            sh_rd_en = (cnt_ff < CNT_DEPTH);
            if (cnt_ff != '0) begin
               prev_in = sh_rd_data;
            end
            if ((cnt_ff >= CNT_W'(2)) && (prev_ff != '0) && (sh_rd_data != '0) &&
                (gap > gap_min_ff)) begin
               sum_in = sum_ff + gap;
            end
            if (cnt_ff == CNT_DEPTH) begin
               state_in  = ST_SW_RD;
               sw_idx_in = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         ST_SW_RD: begin
            sw_rd_en  = 1'b1;
            sum_ok_in = (sum_ff > gap_sum_min_ff);
            state_in  = ST_SW_CHK;
         end

         ST_SW_CHK: begin
            a_in = sw_rd_data;
            if (sw_rd_data == '0) begin
               if (sw_idx_ff == SW_TOP) begin
                  finish = 1'b1;
               end else begin
                  sw_idx_in = sw_idx_ff + SW_AW'(1);
                  state_in  = ST_SW_RD;
               end
            end else begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Stream the sorted vibration ring against one switch timestamp.
            sh_rd_en = (cnt_ff < CNT_DEPTH);
            if ((cnt_ff != '0) && (sh_rd_data != '0) && (abs_diff < match_window_ff)) begin
               finish = 1'b1;
               found  = 1'b1;
            end else if (cnt_ff == CNT_DEPTH) begin
               if (sw_idx_ff == SW_TOP) begin
                  finish = 1'b1;
               end else begin
                  sw_idx_in = sw_idx_ff + SW_AW'(1);
                  state_in  = ST_SW_RD;
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      report = found && sum_ok_ff;
      if (finish) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         rsp_found_in = report;
         rsp_sw_in    = report ? a_ff : '0;
         rsp_sh_in    = report ? sh_rd_data : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pass_ff      <= '0;
         sum_ok_ff    <= 1'b0;
         sw_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pass_ff      <= pass_in;
         sum_ok_ff    <= sum_ok_in;
         sw_idx_ff    <= sw_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      carry_ff     <= carry_in;
      prev_ff      <= prev_in;
      sum_ff       <= sum_in;
      a_ff         <= a_in;
      rsp_found_ff <= rsp_found_in;
      rsp_sw_ff    <= rsp_sw_in;
      rsp_sh_ff    <= rsp_sh_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_found = rsp_found_ff;
   assign rsp_switch_time = rsp_sw_ff;
   assign rsp_shake_time  = rsp_sh_ff;

endmodule
